### sv/acs_pkg.sv
package acs_pkg;

  typedef struct packed {
    logic               action;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] now_ms;
    logic        [15:0] new_count;
  } acs_in_t;

  typedef struct packed {
    logic [15:0] step_count;
    logic        step_seen;
    logic        walking;
  } acs_out_t;

  typedef struct packed {
    logic [15:0] threshold_idle;
    logic [15:0] threshold_walking;
    logic [15:0] pause_limit_ms;
    logic [7:0]  confirm_steps;
  } acs_cfg_t;

  // register word indexes (paddr[3:2])
  localparam logic [1:0] REG_THR_IDLE  = 2'd0;
  localparam logic [1:0] REG_THR_WALK  = 2'd1;
  localparam logic [1:0] REG_PAUSE     = 2'd2;
  localparam logic [1:0] REG_CONFIRM   = 2'd3;

  localparam logic [15:0] THR_IDLE_RST = 16'd1350;
  localparam logic [15:0] THR_WALK_RST = 16'd900;
  localparam logic [15:0] PAUSE_RST    = 16'd2000;
  localparam logic [7:0]  CONFIRM_RST  = 8'd7;

  localparam logic [15:0] RING_INIT    = 16'd5000;

  localparam logic        ACT_SAMPLE   = 1'b0;

  // divide by 3: q = (n * 87382) >> 18, exact for n < 2^17
  localparam logic [16:0] MEAN_RECIP   = 17'd87382;
  localparam int          MEAN_SHIFT   = 18;

endpackage

### sv/acs_regs.sv
module acs_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output acs_pkg::acs_cfg_t cfg
);
  import acs_pkg::*;

  acs_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_idle    <= THR_IDLE_RST;
      cfg_r.threshold_walking <= THR_WALK_RST;
      cfg_r.pause_limit_ms    <= PAUSE_RST;
      cfg_r.confirm_steps     <= CONFIRM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THR_IDLE: cfg_r.threshold_idle    <= pwdata[15:0];
        REG_THR_WALK: cfg_r.threshold_walking <= pwdata[15:0];
        REG_PAUSE:    cfg_r.pause_limit_ms    <= pwdata[15:0];
        REG_CONFIRM:  cfg_r.confirm_steps     <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THR_IDLE: prdata = {16'd0, cfg_r.threshold_idle};
      REG_THR_WALK: prdata = {16'd0, cfg_r.threshold_walking};
      REG_PAUSE:    prdata = {16'd0, cfg_r.pause_limit_ms};
      REG_CONFIRM:  prdata = {24'd0, cfg_r.confirm_steps};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

### sv/acs_mean.sv
// (x + y + z) / 3, truncating toward zero
module acs_mean (
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic signed [15:0] mean
);
  import acs_pkg::*;

  logic signed [17:0] total;
  logic               neg;
  logic [16:0]        mag;
  logic [33:0]        prod;
  logic [15:0]        quo;
  logic [15:0]        quo_s;

  always_comb begin
    total = 18'(accel_x) + 18'(accel_y) + 18'(accel_z);
    neg   = total[17];
    mag   = neg ? 17'(18'd0 - total) : total[16:0];
    prod  = 34'(mag) * 34'(MEAN_RECIP);
    // magnitude quotient is at most 32768
    quo   = prod[MEAN_SHIFT +: 16];
    quo_s = neg ? (16'd0 - quo) : quo;
    mean  = quo_s;
  end

endmodule

### sv/acs_ring.sv
// Ring of past changes with running sum and average.
// Old entry at the write slot is prefetched into a read register ahead of use.
module acs_ring #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [15:0] change,
  output logic [15:0] avg
);
  import acs_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int SUM_W = 16 + IDX_W;
  localparam int SHIFT = SUM_W + IDX_W;
  localparam int RCP_W = SUM_W + 2;
  localparam longint unsigned RCP_VAL =
    ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);
  localparam int PROD_W = SUM_W + RCP_W;

  logic [15:0]           mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] wr_vld_r;
  logic [15:0]           rd_data_r;
  logic                  rd_vld_r;
  logic                  rd_zero_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      idx_nxt;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      sum_nxt;
  logic                  avg_vld_r;
  logic [15:0]           old_val;
  logic [PROD_W-1:0]     prod;

  always_comb begin
    idx_nxt = idx_r;
    if (push) begin
      idx_nxt = (idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : idx_r + 1'b1;
    end
  end

  // never-written slots read as their reset value
  assign old_val = rd_vld_r ? rd_data_r : (rd_zero_r ? RING_INIT : 16'd0);
  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(change);

  assign prod = PROD_W'(sum_r) * PROD_W'(RCP);
  assign avg  = avg_vld_r ? prod[SHIFT +: 16] : 16'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[idx_r] <= change;
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r  <= '0;
      rd_vld_r  <= 1'b0;
      rd_zero_r <= 1'b1;
      idx_r     <= '0;
      sum_r     <= SUM_W'(RING_INIT);
      avg_vld_r <= 1'b0;
    end else begin
      if (push) begin
        wr_vld_r[idx_r] <= 1'b1;
        sum_r           <= sum_nxt;
        avg_vld_r       <= 1'b1;
      end
      idx_r     <= idx_nxt;
      rd_vld_r  <= wr_vld_r[idx_nxt];
      rd_zero_r <= (idx_nxt == '0);
    end
  end

endmodule

### sv/accel_step_counter.sv
// Channel   Ports                         Moves
// input     in_valid/in_ready/in_data     one sample or count-load request
// result    out_valid/out_ready/out_data  count, candidate flag, walking flag
// config    psel/penable/pwrite/paddr...  APB register writes and reads
//
// The mean is formed into the input register, then the step decision, ring
// update and result register follow together. Throughput one request per
// clock unless the result stalls; the ring sum makes the average O(1).
// Synchronous active-low reset clears control state and loads register defaults.
// A stalled result holds in the output register; one more request may wait
// in the input register behind it.
module accel_step_counter #(
  parameter int RING_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  acs_pkg::acs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output acs_pkg::acs_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import acs_pkg::*;

  acs_cfg_t           cfg;
  logic signed [15:0] mean_in;

  // input stage
  logic               s1_vld_r;
  logic               s1_action_r;
  logic signed [15:0] s1_mean_r;
  logic [31:0]        s1_now_r;
  logic [15:0]        s1_load_r;

  // output stage
  logic               out_vld_r;
  acs_out_t           out_r;
  acs_out_t           out_nxt;

  // tracker state
  logic signed [15:0] prev_mean_r;
  logic               above_r,  above_nxt;
  logic               walk_r,   walk_nxt;
  logic [7:0]         pend_r,   pend_nxt;
  logic [15:0]        count_r,  count_nxt;
  logic [31:0]        last_ms_r, last_ms_nxt;

  logic               in_fire;
  logic               adv;
  logic signed [16:0] delta;
  logic [16:0]        delta_abs;
  logic [15:0]        change;
  logic [15:0]        avg;
  logic [15:0]        thr;
  logic signed [17:0] excess;
  logic               hit;
  logic [31:0]        gap;
  logic               ring_push;
  logic               seen;

  acs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acs_mean u_mean (
    .accel_x (in_data.accel_x),
    .accel_y (in_data.accel_y),
    .accel_z (in_data.accel_z),
    .mean    (mean_in)
  );

  acs_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (ring_push),
    .change (change),
    .avg    (avg)
  );

  assign adv       = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || adv;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    delta     = 17'(s1_mean_r) - 17'(prev_mean_r);
    delta_abs = delta[16] ? (17'd0 - delta) : delta;
    change    = delta_abs[15:0];
    thr       = walk_r ? cfg.threshold_walking : cfg.threshold_idle;
    // signed excess, so a change under the average never counts
    excess    = $signed({2'b00, change}) - $signed({2'b00, avg});
    hit       = excess > $signed({2'b00, thr});
    gap       = s1_now_r - last_ms_r;
  end

  always_comb begin
    above_nxt   = above_r;
    walk_nxt    = walk_r;
    pend_nxt    = pend_r;
    count_nxt   = count_r;
    last_ms_nxt = last_ms_r;
    ring_push   = 1'b0;
    seen        = 1'b0;
    if (s1_action_r != ACT_SAMPLE) begin
      count_nxt = s1_load_r;
    end else if (hit) begin
      if (!above_r) begin
        seen        = 1'b1;
        above_nxt   = 1'b1;
        last_ms_nxt = s1_now_r;
        priority if (gap > {16'd0, cfg.pause_limit_ms}) begin
          pend_nxt = 8'd1;
          walk_nxt = 1'b0;
        end else if (walk_r) begin
          count_nxt = count_r + 16'd1;
        end else if (pend_r >= cfg.confirm_steps) begin
          walk_nxt  = 1'b1;
          count_nxt = count_r + {8'd0, pend_r} + 16'd1;
        end else begin
          pend_nxt = pend_r + 8'd1;
        end
      end
    end else begin
      above_nxt = 1'b0;
      ring_push = adv;
    end
    out_nxt.step_count = count_nxt;
    out_nxt.step_seen  = seen;
    out_nxt.walking    = walk_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_data.action;
      s1_mean_r   <= mean_in;
      s1_now_r    <= in_data.now_ms;
      s1_load_r   <= in_data.new_count;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      prev_mean_r <= '0;
      above_r     <= 1'b0;
      walk_r      <= 1'b0;
      pend_r      <= '0;
      count_r     <= '0;
      last_ms_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (adv) begin
        if (s1_action_r == ACT_SAMPLE) begin
          prev_mean_r <= s1_mean_r;
        end
        above_r   <= above_nxt;
        walk_r    <= walk_nxt;
        pend_r    <= pend_nxt;
        count_r   <= count_nxt;
        last_ms_r <= last_ms_nxt;
      end
    end
  end

endmodule

### tb/acs_step_checker.sv
module acs_step_checker #(
  parameter int RING_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  acs_pkg::acs_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  acs_pkg::acs_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                mismatches,
  output int                results_due
);
  import acs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  acs_cfg_t    cfg;
  int          prev_mean;
  logic [15:0] change_ring [RING_DEPTH];
  int unsigned ring_total;
  int          ring_pos;
  logic [15:0] avg_change;
  logic        over_thr;
  logic        walk_mode;
  logic [7:0]  candidates;
  logic [15:0] step_total;
  logic [31:0] last_cand_ms;
  acs_out_t    step_results_q[$];
  acs_out_t    due;

  function automatic void clear_tracker();
    cfg.threshold_idle    = THR_IDLE_RST;
    cfg.threshold_walking = THR_WALK_RST;
    cfg.pause_limit_ms    = PAUSE_RST;
    cfg.confirm_steps     = CONFIRM_RST;
    prev_mean = 0;
    foreach (change_ring[i]) change_ring[i] = '0;
    change_ring[0] = RING_INIT;
    ring_total = 32'(RING_INIT);
    ring_pos = 0;
    avg_change = '0;
    over_thr = 1'b0;
    walk_mode = 1'b0;
    candidates = '0;
    step_total = '0;
    last_cand_ms = '0;
  endfunction

  function automatic void note_candidate(logic [31:0] now);
    logic [31:0] since;
    since = now - last_cand_ms;
    if (since > 32'(cfg.pause_limit_ms)) begin
      candidates = 8'd1;
      walk_mode = 1'b0;
    end else if (walk_mode) begin
      step_total = step_total + 16'd1;
    end else if (candidates >= cfg.confirm_steps) begin
      // buffered candidates plus this one are committed at once
      walk_mode = 1'b1;
      step_total = step_total + 16'(candidates) + 16'd1;
    end else begin
      candidates = candidates + 8'd1;
    end
    last_cand_ms = now;
  endfunction

  function automatic acs_out_t predict_step(acs_in_t req);
    int          mean;
    int          delta;
    logic [15:0] change;
    logic [15:0] thr;
    logic        seen;
    acs_out_t    res;
    seen = 1'b0;
    if (req.action != ACT_SAMPLE) begin
      step_total = req.new_count;
    end else begin
      mean = (int'($signed(req.accel_x)) + int'($signed(req.accel_y)) +
              int'($signed(req.accel_z))) / 3;
      delta = mean - prev_mean;
      change = 16'(delta < 0 ? -delta : delta);
      thr = walk_mode ? cfg.threshold_walking : cfg.threshold_idle;
      prev_mean = mean;
      // signed margin: a change under the average never qualifies
      if (int'(change) - int'(avg_change) > int'(thr)) begin
        if (!over_thr) begin
          note_candidate(req.now_ms);
          over_thr = 1'b1;
          seen = 1'b1;
        end
      end else begin
        over_thr = 1'b0;
        ring_total = ring_total - change_ring[ring_pos] + change;
        change_ring[ring_pos] = change;
        avg_change = 16'(ring_total / RING_DEPTH);
        ring_pos = (ring_pos == RING_DEPTH - 1) ? 0 : ring_pos + 1;
      end
    end
    res.step_count = step_total;
    res.step_seen  = seen;
    res.walking    = walk_mode;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tracker();
      step_results_q.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_THR_IDLE: cfg.threshold_idle    = pwdata[15:0];
          REG_THR_WALK: cfg.threshold_walking = pwdata[15:0];
          REG_PAUSE:    cfg.pause_limit_ms    = pwdata[15:0];
          REG_CONFIRM:  cfg.confirm_steps     = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (step_results_q.size() == 0) begin
          $error("result with no request outstanding: step_count %0d", out_data.step_count);
          mismatches++;
        end else begin
          due = step_results_q.pop_front();
          if (out_data.step_count !== due.step_count) begin
            $error("step_count: expected %0d, actual %0d", due.step_count, out_data.step_count);
            mismatches++;
          end
          if (out_data.step_seen !== due.step_seen) begin
            $error("step_seen: expected %0b, actual %0b", due.step_seen, out_data.step_seen);
            mismatches++;
          end
          if (out_data.walking !== due.walking) begin
            $error("walking: expected %0b, actual %0b", due.walking, out_data.walking);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) step_results_q.push_back(predict_step(in_data));
    end
    results_due = step_results_q.size();
  end

endmodule

### tb/accel_step_counter_test.sv
module accel_step_counter_test;
  import acs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RING_DEPTH  = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic        ACT_LOAD    = !ACT_SAMPLE;
  localparam logic [31:0] T_WRAP      = 32'hFFFF_FE00;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_ready;
  acs_in_t     in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  acs_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          results_due;
  int          items_sent = 0;
  int          pause_ms = int'(PAUSE_RST);
  logic [31:0] clock_ms = '0;
  logic        calm = 1'b0;
  logic        rx_hold_req = 1'b0;
  logic        rx_hold_seen = 1'b0;
  int          rx_hold_left = 0;
  int unsigned cycle_count = 0;

  accel_step_counter #(.RING_DEPTH(RING_DEPTH)) i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  acs_step_checker #(.RING_DEPTH(RING_DEPTH)) i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches(fail_count), .results_due(results_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = 250;
    end
    if (rx_hold_left > 0) begin
      out_ready = 1'b0;
      rx_hold_left--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ready = 1'b0;
      rx_hold_left = (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                      $urandom_range(1, 3)) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic send_item(input acs_in_t req);
    int gap;
    @(negedge clk);
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(input logic [15:0] thr_i, input logic [15:0] thr_w,
                            input logic [15:0] pause, input logic [7:0] confirm);
    drain();
    write_reg(REG_THR_IDLE, thr_i);
    write_reg(REG_THR_WALK, thr_w);
    write_reg(REG_PAUSE, pause);
    write_reg(REG_CONFIRM, 16'(confirm));
    pause_ms = int'(pause);
  endtask

  function automatic acs_in_t axes(input int x, input int y, input int z,
                                   input logic [31:0] now);
    acs_in_t req;
    req.action = ACT_SAMPLE;
    req.accel_x = 16'(x);
    req.accel_y = 16'(y);
    req.accel_z = 16'(z);
    req.now_ms = now;
    req.new_count = 16'($urandom);
    return req;
  endfunction

  function automatic acs_in_t sample_at(input int m, input int jitter, input logic [31:0] now);
    return axes(m + int'($urandom_range(0, 2 * jitter)) - jitter,
                m + int'($urandom_range(0, 2 * jitter)) - jitter,
                m + int'($urandom_range(0, 2 * jitter)) - jitter, now);
  endfunction

  function automatic acs_in_t load_of(input logic [15:0] count);
    acs_in_t req;
    req = axes(int'($urandom), int'($urandom), int'($urandom), $urandom);
    req.action = ACT_LOAD;
    req.new_count = count;
    return req;
  endfunction

  function automatic acs_in_t noise_item();
    return axes(int'($urandom), int'($urandom), int'($urandom), $urandom);
  endfunction

  // spike, return to rest, settle: the settle clears the above-threshold latch
  task automatic spike_trio(input int m, input logic [31:0] now);
    send_item(axes(m, m, m, now));
    send_item(axes(0, 0, 0, now));
    send_item(axes(0, 0, 0, now));
  endtask

  task automatic walk_burst(input int spikes, input int target);
    int base;
    int amp;
    int gap;
    int rests;
    base = int'($urandom_range(0, 4000)) - 2000;
    for (int k = 0; k < spikes && items_sent < target; k++) begin
      case ($urandom_range(0, 7))
        0:       gap = pause_ms + 1 + int'($urandom_range(0, 3000));
        1:       gap = pause_ms + int'($urandom_range(0, 1));
        default: gap = int'($urandom_range(0, pause_ms));
      endcase
      clock_ms = clock_ms + 32'(gap);
      amp = int'($urandom_range(800, 30000));
      send_item(sample_at(base + (($urandom_range(0, 1) == 1) ? amp : -amp), 40, clock_ms));
      send_item(sample_at(base, 40, clock_ms + $urandom_range(0, 40)));
      rests = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      repeat (rests) send_item(sample_at(base, 20, clock_ms + $urandom_range(0, 80)));
    end
  endtask

  task automatic random_traffic(input int count);
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        walk_burst($urandom_range(1, 12), target);
      end else if (pick < 17) begin
        send_item(noise_item());
      end else if (pick < 19) begin
        send_item(load_of(($urandom_range(0, 1) == 1) ? 16'($urandom) :
                          16'hFFFF - 16'($urandom_range(0, 15))));
      end else begin
        // lone spike with no return
        send_item(sample_at(int'($urandom_range(0, 60000)) - 30000, 40,
                            clock_ms + $urandom_range(0, 500)));
      end
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: confirm on the first candidate that follows in time
    write_reg(REG_CONFIRM, 16'd0);
    send_item(load_of(16'hFFFF));
    send_item(axes(0, 0, 0, 32'd0));
    send_item(axes(32767, 32767, 32767, T_WRAP));
    send_item(axes(-32768, -32768, -32768, T_WRAP + 1));
    send_item(axes(32767, -32768, 1, T_WRAP + 2));
    send_item(axes(-1, -1, 0, T_WRAP + 3));
    send_item(axes(-2, -2, -1, T_WRAP + 4));
    send_item(axes(100, 100, 100, T_WRAP + 5));
    send_item(axes(0, 0, 0, 32'hFFFF_FFFF));
    clock_ms = T_WRAP + 300;
    spike_trio(5000, clock_ms);
    clock_ms = clock_ms + 300;
    spike_trio(5000, clock_ms);
    clock_ms = clock_ms + 32'(PAUSE_RST);
    spike_trio(5000, clock_ms);
    clock_ms = clock_ms + 32'(PAUSE_RST) + 1;
    spike_trio(5000, clock_ms);
    send_item(load_of(16'd0));
    clock_ms = clock_ms + 100;
    spike_trio(-5000, clock_ms);

    set_config(THR_IDLE_RST, THR_WALK_RST, PAUSE_RST, CONFIRM_RST);
    random_traffic(150);
    rx_hold_req = !rx_hold_req;
    random_traffic(100);
    drain();
    random_traffic(100);

    set_config(16'd0, 16'd0, 16'd0, 8'd0);
    calm = 1'b1;
    random_traffic(200);
    calm = 1'b0;

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    random_traffic(150);

    repeat (5) begin
      int thr_i;
      thr_i = $urandom_range(200, 4000);
      set_config(16'(thr_i), 16'($urandom_range(100, thr_i)),
                 16'($urandom_range(200, 5000)), 8'($urandom_range(0, 12)));
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : $urandom;
      random_traffic(260);
    end

    drain();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
sv/acs_pkg.sv
sv/acs_regs.sv
sv/acs_mean.sv
sv/acs_ring.sv
sv/accel_step_counter.sv
tb/acs_step_checker.sv
tb/accel_step_counter_test.sv
